/* src/bcc_pkg.sv */
// Shared types, constants and decode helpers for the byte-coded CPU step core.
`timescale 1ns / 1ps
package bcc_pkg;

  localparam int ADDR_BITS_DEF = 16;

  localparam logic [15:0] PC_RESET = 16'h0040;
  localparam logic [15:0] SP_RESET = 16'd1028;
  localparam logic [15:0] CR_RESET = 16'h0001;

  localparam logic [1:0] ITEM_WRITE = 2'd0;
  localparam logic [1:0] ITEM_STEP  = 2'd1;
  localparam logic [1:0] ITEM_READ  = 2'd2;

  localparam logic [7:0] INS_INT = 8'h01;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_HOST_WR, DP_HOST_RD, DP_TICK, DP_INT, DP_FETCH,
    DP_HALT, DP_IMM_RD, DP_EXEC, DP_JRE, DP_SET, DP_LD_LO, DP_LD_HI,
    DP_LD_WB, DP_ST_LO, DP_ST_HI
  } dp_op_t;

  typedef enum logic [3:0] {
    R_PC, R_SP, R_DP, R_CR, R_A, R_B, R_C, R_D, R_L, R_P
  } reg_id_t;

  typedef enum logic [2:0] {
    IC_INT, IC_IMM, IC_LOAD, IC_STORE, IC_SIMPLE
  } ins_class_t;

  typedef struct packed {
    dp_op_t      op;
    logic        load_ir;
    logic [15:0] clr_addr;
  } dp_cmd_t;

  typedef struct packed {
    logic       halted;
    logic       int_pend;
    logic [7:0] mem_q;
    logic [7:0] ir;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] cr;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    logic [15:0] d;
    logic [15:0] l;
    logic [15:0] p;
  } cpu_regs_t;

  typedef struct packed {
    logic capture;
    logic rd_item;
  } out_ctl_t;

  function automatic ins_class_t ins_class(input logic [7:0] ins);
    ins_class_t k;
    if (ins == INS_INT) k = IC_INT;
    else if (ins[7:2] == 6'b000001 || ins[7:6] == 2'b11) k = IC_IMM;
    else if (ins[7:4] == 4'h2) k = IC_LOAD;
    else if (ins[7:4] == 4'h3) k = IC_STORE;
    else k = IC_SIMPLE;
    return k;
  endfunction

  function automatic reg_id_t ptr_id(input logic [1:0] s);
    reg_id_t r;
    unique case (s)
      2'd0: r = R_C;
      2'd1: r = R_D;
      2'd2: r = R_SP;
      default: r = R_DP;
    endcase
    return r;
  endfunction

  function automatic reg_id_t acc_id(input logic [1:0] s);
    reg_id_t r;
    unique case (s)
      2'd0: r = R_A;
      2'd1: r = R_B;
      2'd2: r = R_C;
      default: r = R_L;
    endcase
    return r;
  endfunction

  function automatic reg_id_t mov_src_id(input logic [2:0] s);
    reg_id_t r;
    unique case (s)
      3'd0: r = R_A;
      3'd1: r = R_C;
      3'd2: r = R_D;
      3'd3: r = R_L;
      3'd4: r = R_P;
      3'd5: r = R_SP;
      3'd6: r = R_DP;
      default: r = R_PC;
    endcase
    return r;
  endfunction

  function automatic reg_id_t mov_dst_id(input logic [2:0] s);
    reg_id_t r;
    unique case (s)
      3'd0: r = R_B;
      3'd1: r = R_C;
      3'd2: r = R_D;
      3'd3: r = R_L;
      3'd4: r = R_P;
      3'd5: r = R_SP;
      3'd6: r = R_DP;
      default: r = R_CR;
    endcase
    return r;
  endfunction

  function automatic reg_id_t set_dst_id(input logic [2:0] s);
    reg_id_t r;
    unique case (s)
      3'd0: r = R_A;
      3'd1: r = R_B;
      3'd2: r = R_C;
      3'd3: r = R_D;
      3'd4: r = R_L;
      3'd5: r = R_P;
      3'd6: r = R_DP;
      default: r = R_CR;
    endcase
    return r;
  endfunction

endpackage

/* src/bcc_if.sv */
// Valid/ready channel interfaces for the item input and the result output.
`timescale 1ns / 1ps
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;
  modport source (output valid, opcode, address, write_data, input ready);
  modport sink (input valid, opcode, address, write_data, output ready);
endinterface

interface bcc_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] prog_counter;
  logic signed [15:0] acc_a;
  logic signed [15:0] reg_b;
  logic signed [15:0] reg_c;
  logic signed [15:0] reg_d;
  logic signed [15:0] reg_l;
  logic signed [15:0] reg_p;
  logic        [15:0] stack_ptr;
  logic        [15:0] data_ptr;
  logic        [15:0] control_word;
  logic        [7:0]  read_data;
  logic               halted;
  modport source (output valid, prog_counter, acc_a, reg_b, reg_c, reg_d, reg_l, reg_p,
                  stack_ptr, data_ptr, control_word, read_data, halted, input ready);
  modport sink (input valid, prog_counter, acc_a, reg_b, reg_c, reg_d, reg_l, reg_p,
                stack_ptr, data_ptr, control_word, read_data, halted, output ready);
endinterface

/* src/byte_coded_cpu_step_core.sv */
// Top level of the byte-coded CPU step core: controller, datapath, result register.
//
//   channel  direction  contents
//   in_ch    sink       opcode, address, write_data
//   out_ch   source     registers, control_word, read_data, halted
//
// After reset the core clears every byte of its memory, one byte per cycle,
// before in_ch.ready first rises.
// A write or read item passes from the idle state straight to the done state. A
// step of a halted core does the same; otherwise the timer ticks and a pending
// interrupt skips the fetch. Any other step is paced by the single memory port:
// the opcode fetch, then an optional immediate byte or two bytes of a 16-bit access.
// A finished result waits in the output register while the next item is taken.
`timescale 1ns / 1ps
module byte_coded_cpu_step_core #(
  parameter int ADDR_BITS = bcc_pkg::ADDR_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bcc_in_if.sink    in_ch,
  bcc_out_if.source out_ch
);

  bcc_pkg::dp_cmd_t   cmd;
  bcc_pkg::dp_stat_t  stat;
  bcc_pkg::cpu_regs_t regs;
  bcc_pkg::out_ctl_t  octl;

  logic [15:0] host_addr;
  logic [7:0]  host_wdata;

  // The datapath takes write and read items in the accept cycle itself.
  assign host_addr  = in_ch.address;
  assign host_wdata = in_ch.write_data;

  bcc_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd),
    .octl      (octl)
  );

  bcc_dpath #(.ADDR_BITS(ADDR_BITS)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .host_addr  (host_addr),
    .host_wdata (host_wdata),
    .stat       (stat),
    .regs       (regs)
  );

  // Result register: loaded from the architectural state when an item finishes.
  always_ff @(posedge clk) begin
    if (octl.capture) begin
      out_ch.prog_counter <= regs.pc;
      out_ch.acc_a        <= $signed(regs.a);
      out_ch.reg_b        <= $signed(regs.b);
      out_ch.reg_c        <= $signed(regs.c);
      out_ch.reg_d        <= $signed(regs.d);
      out_ch.reg_l        <= $signed(regs.l);
      out_ch.reg_p        <= $signed(regs.p);
      out_ch.stack_ptr    <= regs.sp;
      out_ch.data_ptr     <= regs.dp;
      out_ch.control_word <= regs.cr;
      out_ch.read_data    <= octl.rd_item ? stat.mem_q : 8'h00;
      out_ch.halted       <= stat.halted;
    end
  end

endmodule

/* src/bcc_dpath.sv */
// Datapath: register file, timer, byte memory and instruction execution.
`timescale 1ns / 1ps
module bcc_dpath #(
  parameter int ADDR_BITS = bcc_pkg::ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bcc_pkg::dp_cmd_t   cmd,
  input  logic [15:0]        host_addr,
  input  logic [7:0]         host_wdata,
  output bcc_pkg::dp_stat_t  stat,
  output bcc_pkg::cpu_regs_t regs
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0] mem [DEPTH];

  logic [15:0] pc_r, sp_r, dp_r, cr_r, a_r, b_r, c_r, d_r, l_r, p_r;
  logic [15:0] pc_nxt, sp_nxt, dp_nxt, cr_nxt, a_nxt, b_nxt, c_nxt, d_nxt, l_nxt, p_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        halt_r, halt_nxt;
  logic [7:0]  ir_r, mem_q_r, lo_r, lo_nxt;

  logic [7:0]           cur_ins;
  logic [15:0]          ptr_val, ptr_hi, src_val;
  logic                 rd_en, wr_en;
  logic [ADDR_BITS-1:0] rd_addr, wr_addr;
  logic [7:0]           wr_data;

  function automatic logic [15:0] get_reg(input bcc_pkg::reg_id_t id,
                                          input bcc_pkg::cpu_regs_t r);
    logic [15:0] v;
    unique case (id)
      bcc_pkg::R_PC: v = r.pc;
      bcc_pkg::R_SP: v = r.sp;
      bcc_pkg::R_DP: v = r.dp;
      bcc_pkg::R_CR: v = r.cr;
      bcc_pkg::R_A:  v = r.a;
      bcc_pkg::R_B:  v = r.b;
      bcc_pkg::R_C:  v = r.c;
      bcc_pkg::R_D:  v = r.d;
      bcc_pkg::R_L:  v = r.l;
      bcc_pkg::R_P:  v = r.p;
      default:       v = 16'h0000;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] shl16(input logic [15:0] v, input logic [15:0] n);
    return (n >= 16'd16) ? 16'h0000 : (v << n[3:0]);
  endfunction

  function automatic logic [15:0] asr16(input logic [15:0] v, input logic [15:0] n);
    logic [15:0] r;
    if (n >= 16'd16) r = {16{v[15]}};
    else r = 16'($signed(v) >>> n[3:0]);
    return r;
  endfunction

  assign regs = '{pc: pc_r, sp: sp_r, dp: dp_r, cr: cr_r, a: a_r, b: b_r,
                  c: c_r, d: d_r, l: l_r, p: p_r};

  assign cur_ins = cmd.load_ir ? mem_q_r : ir_r;
  assign ptr_val = get_reg(bcc_pkg::ptr_id(cur_ins[3:2]), regs);
  assign ptr_hi  = ptr_val + 16'd1;
  assign src_val = get_reg(bcc_pkg::acc_id(cur_ins[1:0]), regs);

  assign stat = '{halted: halt_r, int_pend: |cr_r[5:4], mem_q: mem_q_r, ir: ir_r};

  // Memory port selection.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pc_r[ADDR_BITS-1:0];
    wr_en   = 1'b0;
    wr_addr = host_addr[ADDR_BITS-1:0];
    wr_data = host_wdata;
    case (cmd.op)
      bcc_pkg::DP_HOST_RD: begin
        rd_en   = 1'b1;
        rd_addr = host_addr[ADDR_BITS-1:0];
      end
      bcc_pkg::DP_FETCH, bcc_pkg::DP_IMM_RD: rd_en = 1'b1;
      bcc_pkg::DP_LD_LO: begin
        rd_en   = 1'b1;
        rd_addr = ptr_val[ADDR_BITS-1:0];
      end
      bcc_pkg::DP_LD_HI: begin
        rd_en   = 1'b1;
        rd_addr = ptr_hi[ADDR_BITS-1:0];
      end
      bcc_pkg::DP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cmd.clr_addr[ADDR_BITS-1:0];
        wr_data = 8'h00;
      end
      bcc_pkg::DP_HOST_WR: wr_en = 1'b1;
      bcc_pkg::DP_ST_LO: begin
        wr_en   = 1'b1;
        wr_addr = ptr_val[ADDR_BITS-1:0];
        wr_data = src_val[7:0];
      end
      bcc_pkg::DP_ST_HI: begin
        wr_en   = 1'b1;
        wr_addr = ptr_hi[ADDR_BITS-1:0];
        wr_data = src_val[15:8];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) mem_q_r <= mem[rd_addr];
  end

  // Register updates.
  always_comb begin
    logic              wr_reg;
    bcc_pkg::reg_id_t  wr_id;
    logic [15:0]       wr_val;
    logic [31:0]       tgt;
    logic [15:0]       keep, imm, base;
    logic signed [15:0] x, y;
    logic              t, f, alt;
    bcc_pkg::reg_id_t  pid;

    pc_nxt = pc_r; sp_nxt = sp_r; dp_nxt = dp_r; cr_nxt = cr_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; l_nxt = l_r; p_nxt = p_r;
    tick_nxt = tick_r;
    halt_nxt = halt_r;
    lo_nxt   = lo_r;
    wr_reg = 1'b0;
    wr_id  = bcc_pkg::R_A;
    wr_val = 16'h0000;
    tgt  = 32'(cr_r[11:8]) << cr_r[15:12];
    tgt  = tgt << 4;
    keep = 16'h0000;
    imm  = 16'h0000;
    base = 16'h0000;
    alt  = cur_ins[5];
    x = alt ? l_r : a_r;
    y = alt ? c_r : b_r;
    t = 1'b0;
    f = cr_r[3];
    pid = bcc_pkg::ptr_id(cur_ins[3:2]);

    case (cmd.op)
      bcc_pkg::DP_TICK: begin
        tick_nxt = tick_r + 32'd1;
        if ((cr_r[15:8] != 8'h00) && (tick_nxt == tgt)) begin
          tick_nxt = 32'd0;
          cr_nxt   = cr_r | 16'h0010;
        end
      end
      bcc_pkg::DP_INT: begin
        pc_nxt = cr_r & 16'h0030;
        cr_nxt = cr_r & 16'hFFCF;
      end
      bcc_pkg::DP_FETCH, bcc_pkg::DP_IMM_RD: pc_nxt = pc_r + 16'd1;
      bcc_pkg::DP_HALT: halt_nxt = 1'b1;
      bcc_pkg::DP_EXEC: begin
        if (cur_ins[7:1] == 7'b0000001) begin
          a_nxt = l_r;
          l_nxt = a_r;
        end else if (cur_ins[7:4] == 4'h1) begin
          case (cur_ins[3:0])
            4'h0: a_nxt = a_r + 16'd1;
            4'h1: a_nxt = a_r - 16'd1;
            4'h2: a_nxt = 16'd0 - a_r;
            4'h3: a_nxt = c_r;
            4'h4: a_nxt = 16'h0000;
            4'h5: a_nxt = a_r + c_r;
            4'h6: a_nxt = a_r - c_r;
            4'h7: a_nxt = shl16(a_r, c_r);
            4'h8: a_nxt = asr16(a_r, c_r);
            4'h9: a_nxt = shl16(a_r, 16'd1);
            4'hA: a_nxt = asr16(a_r, 16'd1);
            4'hB: a_nxt = shl16(16'd1, c_r);
            4'hC: a_nxt = a_r & c_r;
            4'hD: a_nxt = a_r | c_r;
            4'hE: a_nxt = a_r ^ c_r;
            default: a_nxt = ~a_r;
          endcase
        end else if (cur_ins[7:6] == 2'b01) begin
          case (cur_ins[2:0])
            3'd0: t = (x == 16'sd0);
            3'd1: t = (x < y);
            3'd2: t = (x == y);
            3'd3: t = (x <= y);
            3'd4: t = (x > y);
            3'd5: t = (x >= y);
            3'd6: t = (x != y);
            default: t = (x != 16'sd0);
          endcase
          if (alt && t && cur_ins[2:0] == 3'd1) l_nxt = l_r + 16'd1;
          if (alt && t && cur_ins[2:0] == 3'd4) l_nxt = l_r - 16'd1;
          case (cur_ins[4:3])
            2'd0: f = t;
            2'd1: f = f & t;
            2'd2: f = f | t;
            default: f = f ^ t;
          endcase
          cr_nxt = {cr_r[15:4], f, cr_r[2:0]};
        end else if (cur_ins[7:6] == 2'b10) begin
          wr_reg = 1'b1;
          wr_id  = bcc_pkg::mov_dst_id(cur_ins[2:0]);
          wr_val = get_reg(bcc_pkg::mov_src_id(cur_ins[5:3]), regs);
        end
      end
      bcc_pkg::DP_JRE: begin
        base = ir_r[0] ? pc_r : p_r;
        if (!ir_r[1] || cr_r[3]) pc_nxt = base + {{8{mem_q_r[7]}}, mem_q_r};
      end
      bcc_pkg::DP_SET: begin
        keep = (ir_r[4] ? 16'h0000 : 16'hFF00) | (ir_r[5] ? 16'h0000 : 16'h00FF);
        imm  = ir_r[3] ? {8'h00, mem_q_r} : {mem_q_r, 8'h00};
        wr_reg = 1'b1;
        wr_id  = bcc_pkg::set_dst_id(ir_r[2:0]);
        wr_val = (get_reg(wr_id, regs) & keep) | imm;
      end
      bcc_pkg::DP_LD_HI: lo_nxt = mem_q_r;
      bcc_pkg::DP_LD_WB: begin
        wr_reg = 1'b1;
        wr_id  = bcc_pkg::acc_id(ir_r[1:0]);
        wr_val = {mem_q_r, lo_r};
        if (pid == bcc_pkg::R_SP) sp_nxt = sp_r + 16'd2;
        if (pid == bcc_pkg::R_DP) dp_nxt = dp_r - 16'd2;
      end
      bcc_pkg::DP_ST_HI: begin
        if (pid == bcc_pkg::R_SP) sp_nxt = sp_r - 16'd2;
        if (pid == bcc_pkg::R_DP) dp_nxt = dp_r + 16'd2;
      end
      default: ;
    endcase

    // A write to CR outside system mode only raises the privilege interrupt.
    if (wr_reg) begin
      if (wr_id == bcc_pkg::R_CR && !cr_r[0]) begin
        cr_nxt = cr_r | 16'h0020;
      end else begin
        unique case (wr_id)
          bcc_pkg::R_PC: pc_nxt = wr_val;
          bcc_pkg::R_SP: sp_nxt = wr_val;
          bcc_pkg::R_DP: dp_nxt = wr_val;
          bcc_pkg::R_CR: cr_nxt = wr_val;
          bcc_pkg::R_A:  a_nxt = wr_val;
          bcc_pkg::R_B:  b_nxt = wr_val;
          bcc_pkg::R_C:  c_nxt = wr_val;
          bcc_pkg::R_D:  d_nxt = wr_val;
          bcc_pkg::R_L:  l_nxt = wr_val;
          bcc_pkg::R_P:  p_nxt = wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= bcc_pkg::PC_RESET;
      sp_r <= bcc_pkg::SP_RESET;
      dp_r <= 16'h0000;
      cr_r <= bcc_pkg::CR_RESET;
      a_r <= 16'h0000; b_r <= 16'h0000; c_r <= 16'h0000;
      d_r <= 16'h0000; l_r <= 16'h0000; p_r <= 16'h0000;
      tick_r <= 32'd0;
      halt_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt; sp_r <= sp_nxt; dp_r <= dp_nxt; cr_r <= cr_nxt;
      a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt;
      d_r <= d_nxt; l_r <= l_nxt; p_r <= p_nxt;
      tick_r <= tick_nxt;
      halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    if (cmd.load_ir) ir_r <= mem_q_r;
  end

endmodule

/* src/bcc_ctrl.sv */
// Controller: sequences memory clearing, item handling and CPU step phases.
`timescale 1ns / 1ps
module bcc_ctrl #(
  parameter int ADDR_BITS = bcc_pkg::ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_opcode,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  bcc_pkg::dp_stat_t stat,
  output bcc_pkg::dp_cmd_t  cmd,
  output bcc_pkg::out_ctl_t octl
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TICK, S_CHECK, S_INS, S_IMM, S_LD_HI, S_LD_WB, S_ST_HI, S_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 rd_item_r, rd_item_nxt;
  logic                 accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_item_nxt   = rd_item_r;
    cmd           = '{op: bcc_pkg::DP_NOP, load_ir: 1'b0, clr_addr: 16'(clr_cnt_r)};
    octl          = '{capture: 1'b0, rd_item: rd_item_r};
    unique case (state_r)
      S_CLEAR: begin
        cmd.op      = bcc_pkg::DP_CLEAR;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          rd_item_nxt = (in_opcode == bcc_pkg::ITEM_READ);
          state_nxt   = S_DONE;
          case (in_opcode)
            bcc_pkg::ITEM_WRITE: cmd.op = bcc_pkg::DP_HOST_WR;
            bcc_pkg::ITEM_READ:  cmd.op = bcc_pkg::DP_HOST_RD;
            bcc_pkg::ITEM_STEP:  if (!stat.halted) state_nxt = S_TICK;
            default: ;
          endcase
        end
      end
      S_TICK: begin
        cmd.op    = bcc_pkg::DP_TICK;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.int_pend) begin
          cmd.op    = bcc_pkg::DP_INT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = bcc_pkg::DP_FETCH;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        state_nxt = S_DONE;
        if (stat.mem_q == 8'h00) begin
          cmd.op = bcc_pkg::DP_HALT;
        end else begin
          cmd.load_ir = 1'b1;
          unique case (bcc_pkg::ins_class(stat.mem_q))
            bcc_pkg::IC_INT: cmd.op = bcc_pkg::DP_INT;
            bcc_pkg::IC_IMM: begin
              cmd.op    = bcc_pkg::DP_IMM_RD;
              state_nxt = S_IMM;
            end
            bcc_pkg::IC_LOAD: begin
              cmd.op    = bcc_pkg::DP_LD_LO;
              state_nxt = S_LD_HI;
            end
            bcc_pkg::IC_STORE: begin
              cmd.op    = bcc_pkg::DP_ST_LO;
              state_nxt = S_ST_HI;
            end
            default: cmd.op = bcc_pkg::DP_EXEC;
          endcase
        end
      end
      S_IMM: begin
        cmd.op    = (stat.ir[7:6] == 2'b11) ? bcc_pkg::DP_SET : bcc_pkg::DP_JRE;
        state_nxt = S_DONE;
      end
      S_LD_HI: begin
        cmd.op    = bcc_pkg::DP_LD_HI;
        state_nxt = S_LD_WB;
      end
      S_LD_WB: begin
        cmd.op    = bcc_pkg::DP_LD_WB;
        state_nxt = S_DONE;
      end
      S_ST_HI: begin
        cmd.op    = bcc_pkg::DP_ST_HI;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          octl.capture  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      rd_item_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      rd_item_r   <= rd_item_nxt;
    end
  end

endmodule
